// ===== src/ilx_pkg.sv =====
// ilx_pkg: shared types, lane constants and status codes for the interleaved
// lehmer xor cipher unit. No dependencies.
`timescale 1ns / 1ps

package ilx_pkg;

  localparam int POSITION_BITS = 24;

  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam pos_t POS_MAX        = '1;
  localparam pos_t SEED_WORDS     = pos_t'(4);
  localparam pos_t HDR_LO_POS     = pos_t'(4);
  localparam pos_t HDR_HI_POS     = pos_t'(5);
  localparam pos_t SHORT_LAST_POS = pos_t'(15);

  localparam logic [31:0] HEADER_BYTES = 32'd32;

  // modulus is 2^16 - fold, so 2^16 folds back as the small constant
  localparam logic [15:0] LANE_MOD  [4] = '{16'hFFA9, 16'hFF9D, 16'hFFF1, 16'hFFC7};
  localparam logic [15:0] LANE_MUL  [4] = '{16'h3DF3, 16'h1709, 16'hB381, 16'h747B};
  localparam logic [6:0]  LANE_FOLD [4] = '{7'h57, 7'h63, 7'h0F, 7'h39};

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_SIZE_MISMATCH = 2'd1,
    STATUS_TOO_SHORT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [1:0]  lane;
    logic        seed;
    logic        hdr_lo;
    logic        hdr_hi;
    logic        too_short;
    logic        saturated;
    logic [31:0] expected;
  } item_t;

endpackage

// ===== src/ilx_front.sv =====
// ilx_front: input side, tracks word position and lane phase and classifies
// each word into an ilx_pkg::item_t. Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [15:0]    word_in,
  input  logic           last_in,
  output logic           push,
  output ilx_pkg::item_t push_item,
  input  logic           full
);

  ilx_pkg::pos_t pos;
  logic [1:0]    phase;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= '0;
    end else if (push) begin
      if (last_in) begin
        pos   <= '0;
        phase <= '0;
      end else begin
        if (pos != ilx_pkg::POS_MAX) begin
          pos <= pos + ilx_pkg::pos_t'(1);
        end
        phase <= phase + 2'd1;
      end
    end
  end

  always_comb begin
    push_item.word      = word_in;
    push_item.last      = last_in;
    push_item.lane      = phase;
    push_item.seed      = pos < ilx_pkg::SEED_WORDS;
    push_item.hdr_lo    = pos == ilx_pkg::HDR_LO_POS;
    push_item.hdr_hi    = pos == ilx_pkg::HDR_HI_POS;
    push_item.too_short = pos < ilx_pkg::SHORT_LAST_POS;
    push_item.saturated = pos == ilx_pkg::POS_MAX;
    push_item.expected  = ((32'(pos) + 32'd1) << 1) - ilx_pkg::HEADER_BYTES;
  end

  a_phase_tracks_pos: assert property (@(posedge clk) disable iff (rst)
    (pos != ilx_pkg::POS_MAX) |-> (phase == pos[1:0]))
    else $error("lane phase out of step with position");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (push && last_in) |=> (pos == '0 && phase == 2'd0))
    else $error("position not cleared after last word");

endmodule

// ===== src/ilx_queue.sv =====
// ilx_queue: two-entry queue of classified items between front and back.
// Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ilx_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ilx_pkg::item_t head
);

  ilx_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count overflow");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

// ===== src/ilx_back.sv =====
// ilx_back: key pipeline (multiply, fold, fold and reduce), xor, header size
// and status, with the output register. Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  ilx_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    word_out,
  output logic           last_out,
  output logic [1:0]     status
);

  logic [15:0]      lane_keys [4];
  logic [31:0]      header_size;

  logic             s1_valid;
  ilx_pkg::item_t   s1_item;
  logic [31:0]      s1_prod;
  logic             s2_valid;
  ilx_pkg::item_t   s2_item;
  logic [23:0]      s2_fold;

  logic             enable;
  logic [15:0]      key_rd;
  logic [31:0]      prod;
  logic [23:0]      fold1;
  logic [16:0]      fold2;
  logic [15:0]      key_new;
  logic [15:0]      result;
  ilx_pkg::status_t status_next;

  assign enable = !out_valid || !out_stall;
  assign pop    = enable && !empty;

  // stage 1: key times lane multiplier
  assign key_rd = lane_keys[head.lane];
  assign prod   = 32'(key_rd) * 32'(ilx_pkg::LANE_MUL[head.lane]);

  // stage 2: fold high half back in
  assign fold1 = 24'(s1_prod[31:16]) * 24'(ilx_pkg::LANE_FOLD[s1_item.lane])
               + 24'(s1_prod[15:0]);

  // stage 3: second fold, final subtract, xor and status
  always_comb begin
    fold2 = 17'(s2_fold[23:16]) * 17'(ilx_pkg::LANE_FOLD[s2_item.lane])
          + 17'(s2_fold[15:0]);
    if (s2_item.seed) begin
      key_new = (s2_item.word != 16'd0) ? s2_item.word : ilx_pkg::LANE_MOD[s2_item.lane];
      result  = s2_item.word;
    end else begin
      if (fold2 >= 17'(ilx_pkg::LANE_MOD[s2_item.lane])) begin
        key_new = 16'(fold2 - 17'(ilx_pkg::LANE_MOD[s2_item.lane]));
      end else begin
        key_new = fold2[15:0];
      end
      result = s2_item.word ^ key_new;
    end
    priority if (!s2_item.last) begin
      status_next = ilx_pkg::STATUS_OK;
    end else if (s2_item.too_short) begin
      status_next = ilx_pkg::STATUS_TOO_SHORT;
    end else if (s2_item.saturated) begin
      status_next = ilx_pkg::STATUS_SIZE_MISMATCH;
    end else if (header_size != s2_item.expected) begin
      status_next = ilx_pkg::STATUS_SIZE_MISMATCH;
    end else begin
      status_next = ilx_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (enable) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      s1_item  <= head;
      s1_prod  <= prod;
      s2_item  <= s1_item;
      s2_fold  <= fold1;
      word_out <= result;
      last_out <= s2_item.last;
      status   <= status_next;
      if (s2_valid) begin
        lane_keys[s2_item.lane] <= key_new;
        if (s2_item.hdr_lo) begin
          header_size[15:0] <= result;
        end
        if (s2_item.hdr_hi) begin
          header_size[31:16] <= result;
        end
      end
    end
  end

  a_key_reduced: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_item.seed) |-> (key_new < ilx_pkg::LANE_MOD[s2_item.lane]))
    else $error("lane key not reduced below modulus");

  a_status_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_out) |-> (status == ilx_pkg::STATUS_OK))
    else $error("status set on a word that is not last");

endmodule

// ===== src/interleaved_lehmer_xor_cipher_unit.sv =====
// interleaved_lehmer_xor_cipher_unit: top level, joins front, queue and back.
// Depends on ilx_pkg, ilx_front, ilx_queue, ilx_back.
//
//   channel  | handshake            | fields
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_stall  | word_in, last_in
//   output   | out_valid / out_stall| word_out, last_out, status
//
// one word per cycle sustained while the output is not stalled; a word
// passes its queue entry, then the three-stage lane key pipeline (multiply,
// fold, fold and reduce) with each lane key reused every fourth word
// rst clears position, phase, queue and pipeline valids
// output stall freezes the pipeline; the two-entry queue absorbs input
`timescale 1ns / 1ps

module interleaved_lehmer_xor_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] word_in,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] word_out,
  output logic        last_out,
  output logic [1:0]  status
);

  logic           push;
  ilx_pkg::item_t push_item;
  logic           full;
  logic           pop;
  logic           empty;
  ilx_pkg::item_t head;

  ilx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .word_in   (word_in),
    .last_in   (last_in),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  ilx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  ilx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_out  (word_out),
    .last_out  (last_out),
    .status    (status)
  );

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for interleaved_lehmer_xor_cipher_unit, drives whole
// files of words with random idling and back-pressure and checks every output word
// against its own keystream predictor. Depends on ilx_pkg and the cipher unit rtl.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 1800;
  localparam logic [31:0] MODULUS [4] = '{32'hFFA9, 32'hFF9D, 32'hFFF1, 32'hFFC7};
  localparam logic [31:0] MULTIPLIER [4] = '{32'h3DF3, 32'h1709, 32'hB381, 32'h747B};

  typedef struct {
    logic [15:0] word;
    logic        last;
    logic [1:0]  status;
  } plain_t;

  typedef struct {
    logic [15:0]      word;
    logic             last;
    bit               typed;
    logic [15:0]      want_word;
    ilx_pkg::status_t want_status;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] word_in = 16'h0000;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] word_out;
  logic        last_out;
  logic [1:0]  status;

  // predictor state
  logic [15:0]   key [4];
  ilx_pkg::pos_t position;
  logic [1:0]    phase;
  logic [31:0]   header_size;

  plain_t plain_q [$];
  int     mismatches = 0;
  int     sent = 0;
  int     cycle_count = 0;
  int     hold_left = 0;
  bit     gaps_on = 1'b1;

  interleaved_lehmer_xor_cipher_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .word_in(word_in),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_out(word_out),
    .last_out(last_out),
    .status(status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [15:0] first_key(input int lane, input logic [15:0] seed);
    logic [31:0] k;
    k = (seed == 16'h0000) ? MODULUS[lane] : 32'(seed);
    return 16'((k * MULTIPLIER[lane]) % MODULUS[lane]);
  endfunction

  task automatic decrypt_word(input logic [15:0] w, input logic l, output plain_t r);
    logic [31:0] k;
    r.word = w;
    r.last = l;
    r.status = ilx_pkg::STATUS_OK;
    if (position < ilx_pkg::SEED_WORDS) begin
      key[phase] = (w != 16'h0000) ? w : 16'(MODULUS[phase]);
    end else begin
      k = (32'(key[phase]) * MULTIPLIER[phase]) % MODULUS[phase];
      key[phase] = 16'(k);
      r.word = w ^ 16'(k);
      if (position == ilx_pkg::HDR_LO_POS) header_size[15:0] = r.word;
      else if (position == ilx_pkg::HDR_HI_POS) header_size[31:16] = r.word;
    end
    if (l) begin
      if (position < ilx_pkg::SHORT_LAST_POS) r.status = ilx_pkg::STATUS_TOO_SHORT;
      else if (position == ilx_pkg::POS_MAX) r.status = ilx_pkg::STATUS_SIZE_MISMATCH;
      else if (header_size != (32'(position) + 32'd1) * 32'd2 - 32'd32)
        r.status = ilx_pkg::STATUS_SIZE_MISMATCH;
      position = '0;
      phase = 2'd0;
      header_size = 32'd0;
    end else begin
      if (position != ilx_pkg::POS_MAX) position = position + ilx_pkg::pos_t'(1);
      phase = phase + 2'd1;
    end
  endtask

  // offers one word; when typed, the given expectation replaces the predicted one
  task automatic send_word(input logic [15:0] w, input logic l, input bit typed = 1'b0,
                           input logic [15:0] want_word = '0,
                           input ilx_pkg::status_t want_status = ilx_pkg::STATUS_OK);
    plain_t r;
    bit accepted;
    while (gaps_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    word_in <= w;
    last_in <= l;
    do begin
      @(negedge clk);
      accepted = !in_stall;
      if (accepted) begin
        decrypt_word(w, l, r);
        if (typed) begin
          r.word = want_word;
          r.status = want_status;
        end
        plain_q.push_back(r);
        sent++;
      end
      @(posedge clk);
    end while (!accepted);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (plain_q.size() != 0);
  endtask

  task automatic send_file(input int n, input bit good_header);
    logic [15:0] seed [4];
    logic [31:0] size;
    logic [15:0] w;
    for (int l = 0; l < 4; l++) begin
      case ($urandom_range(7))
        0: seed[l] = 16'h0000;
        1: seed[l] = 16'hFFFF;
        2: seed[l] = 16'($urandom_range(32'hFFFF, MODULUS[l] + 1));
        3: seed[l] = 16'(MODULUS[l]);
        default: seed[l] = 16'($urandom);
      endcase
    end
    size = 32'(2 * n) - 32'd32;
    if (!good_header) size = size ^ (32'd1 << $urandom_range(31));
    for (int p = 0; p < n; p++) begin
      if (p < 4) w = seed[p];
      else if (p == 4) w = size[15:0] ^ first_key(0, seed[0]);
      else if (p == 5) w = size[31:16] ^ first_key(1, seed[1]);
      else w = 16'($urandom);
      send_word(w, p == n - 1);
    end
  endtask

  // receiver side: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 28);
      end
    end
  end

  always @(negedge clk) begin : check_out
    plain_t want;
    if (!rst && out_valid && !out_stall) begin
      if (plain_q.size() == 0) begin
        report_mismatch("transfer with nothing pending", int'(word_out), 0);
      end else begin
        want = plain_q.pop_front();
        if (word_out !== want.word)
          report_mismatch("word_out", int'(word_out), int'(want.word));
        if (last_out !== want.last)
          report_mismatch("last_out", int'(last_out), int'(want.last));
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
      end
    end
  end

  initial begin
    vector_t vec [25];
    int n;
    int pick;
    bit held_once;
    bit held_twice;
    bit paused_once;
    vec = '{
      // one-word file
      '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, ilx_pkg::STATUS_TOO_SHORT},
      // zero seeds give an all-zero keystream, header size 0 matches 16 words
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b1, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, ilx_pkg::STATUS_OK},
      '{16'h8000, 1'b0, 1'b1, 16'h8000, ilx_pkg::STATUS_OK},
      '{16'h0001, 1'b0, 1'b1, 16'h0001, ilx_pkg::STATUS_OK},
      '{16'h5555, 1'b0, 1'b1, 16'h5555, ilx_pkg::STATUS_OK},
      '{16'hAAAA, 1'b0, 1'b1, 16'hAAAA, ilx_pkg::STATUS_OK},
      '{16'h7FFF, 1'b0, 1'b1, 16'h7FFF, ilx_pkg::STATUS_OK},
      '{16'h1234, 1'b0, 1'b1, 16'h1234, ilx_pkg::STATUS_OK},
      '{16'hFFFE, 1'b0, 1'b1, 16'hFFFE, ilx_pkg::STATUS_OK},
      '{16'h0F0F, 1'b0, 1'b1, 16'h0F0F, ilx_pkg::STATUS_OK},
      '{16'hF0F0, 1'b1, 1'b1, 16'hF0F0, ilx_pkg::STATUS_OK},
      // seeds at and above the modulus on lanes 0 to 2, short file
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'hFF9D, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'hFFF2, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0001, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000, ilx_pkg::STATUS_OK},
      '{16'h0000, 1'b1, 1'b0, 16'h0000, ilx_pkg::STATUS_OK}
    };
    held_once = 1'b0;
    held_twice = 1'b0;
    paused_once = 1'b0;
    for (int l = 0; l < 4; l++) key[l] = 16'h0000;
    position = '0;
    phase = 2'd0;
    header_size = 32'd0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vec[i])
      send_word(vec[i].word, vec[i].last, vec[i].typed, vec[i].want_word,
                vec[i].want_status);
    drain();

    while (sent < RANDOM_WORDS + 25) begin
      gaps_on = !(sent > 700 && sent < 1000);
      if (!held_once && sent >= 300) begin
        held_once = 1'b1;
        hold_left = 200;
      end
      if (!held_twice && sent >= 1300) begin
        held_twice = 1'b1;
        hold_left = 120;
      end
      pick = $urandom_range(99);
      if (pick < 12) n = $urandom_range(15, 1);
      else if (pick < 20) n = $urandom_range(17, 16);
      else if (pick < 95) n = $urandom_range(48, 18);
      else n = $urandom_range(120, 60);
      send_file(n, $urandom_range(99) >= 15);
      if (!paused_once && sent >= 1500) begin
        paused_once = 1'b1;
        drain();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
